// File: rtl/core/edge_interrupt_line_controller_core_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the edge interrupt line controller
// Clocked checks with and without the reset qualifier
// ---------------------------------------------------------------------------
`ifndef EDGE_INTERRUPT_LINE_CONTROLLER_CORE_MACROS_SVH
`define EDGE_INTERRUPT_LINE_CONTROLLER_CORE_MACROS_SVH

// check that is switched off while reset is held
`define EILC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that also holds across reset
`define EILC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/eilc_pkg.sv
// ---------------------------------------------------------------------------
// eilc_pkg
// Types, codes and helpers shared by the interrupt line controller files
// ---------------------------------------------------------------------------
package eilc_pkg;

  localparam int unsigned REG_W = 32;
  localparam int unsigned IRQ_W = 7;

  // item kinds
  localparam logic [1:0] KIND_LINE  = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_WRITE = 2'd2;

  // register selects
  localparam logic [2:0] SEL_RISE   = 3'd0;
  localparam logic [2:0] SEL_FALL   = 3'd1;
  localparam logic [2:0] SEL_SWTRIG = 3'd2;
  localparam logic [2:0] SEL_UNMASK = 3'd3;
  localparam logic [2:0] SEL_PEND   = 3'd4;

  // line groups; mid and high lines share an interrupt output, direct lines own one
  localparam logic [REG_W-1:0] GRP_DIRECT = 32'h0000_001F;
  localparam logic [REG_W-1:0] GRP_MID    = 32'h0000_03E0;
  localparam logic [REG_W-1:0] GRP_HIGH   = 32'h0000_FC00;

  typedef struct packed {
    logic [1:0]       kind;
    logic [4:0]       line;
    logic             level;
    logic [2:0]       reg_sel;
    logic [REG_W-1:0] write_data;
  } item_t;

  typedef struct packed {
    logic [REG_W-1:0] read_data;
    logic [IRQ_W-1:0] irq_pulse;
    logic             bad_access;
  } result_t;

  typedef struct packed {
    logic [REG_W-1:0] rise_enable;
    logic [REG_W-1:0] fall_enable;
    logic [REG_W-1:0] soft_trigger;
    logic [REG_W-1:0] unmask;
    logic [REG_W-1:0] pending;
    logic [REG_W-1:0] last_levels;
  } state_t;

  function automatic logic [IRQ_W-1:0] pulses_for(input logic [REG_W-1:0] fired);
    logic [IRQ_W-1:0] p;
    p      = '0;
    p[4:0] = fired[4:0];
    p[5]   = |(fired & GRP_MID);
    p[6]   = |(fired & GRP_HIGH);
    return p;
  endfunction

endpackage

// File: rtl/core/eilc_if.sv
// ---------------------------------------------------------------------------
// eilc_in_if / eilc_out_if
// Valid/ready channels for line events, register accesses and results
// ---------------------------------------------------------------------------
interface eilc_in_if
  import eilc_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [1:0]       kind;
  logic [4:0]       line;
  logic             level;
  logic [2:0]       reg_sel;
  logic [REG_W-1:0] write_data;

  modport source (output valid, output kind, output line, output level,
                  output reg_sel, output write_data, input ready);
  modport sink   (input valid, input kind, input line, input level,
                  input reg_sel, input write_data, output ready);
endinterface

interface eilc_out_if
  import eilc_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [REG_W-1:0] read_data;
  logic [IRQ_W-1:0] irq_pulse;
  logic             bad_access;

  modport source (output valid, output read_data, output irq_pulse,
                  output bad_access, input ready);
  modport sink   (input valid, input read_data, input irq_pulse,
                  input bad_access, output ready);
endinterface

// File: rtl/core/eilc_decode.sv
// ---------------------------------------------------------------------------
// eilc_decode
// Next register state and result for one line event or register access
// ---------------------------------------------------------------------------
module eilc_decode
  import eilc_pkg::*;
#(
  parameter int unsigned NUM_LINES = 32
) (
  input  item_t   item,
  input  state_t  st,
  output state_t  st_nxt,
  output result_t res
);

  localparam logic [REG_W:0]   ONE       = (REG_W + 1)'(1);
  localparam logic [REG_W-1:0] LINE_MASK = REG_W'((ONE << NUM_LINES) - ONE);
  localparam logic [5:0]       LINE_LIM  = 6'(NUM_LINES);

  logic [REG_W-1:0] bit_sel;
  logic [REG_W-1:0] armed;
  logic [REG_W-1:0] fired;
  logic             old_lvl;
  logic             in_range;
  logic             sel_bad;

  always_comb begin
    bit_sel  = REG_W'(1) << item.line;
    in_range = {1'b0, item.line} < LINE_LIM;
    old_lvl  = |(st.last_levels & bit_sel);
    armed    = item.level ? st.rise_enable : st.fall_enable;
    sel_bad  = item.reg_sel > SEL_PEND;
    fired    = '0;
    st_nxt   = st;
    res      = '0;

    case (item.kind)
      KIND_LINE: begin
        if (in_range) begin
          st_nxt.last_levels = item.level ? (st.last_levels | bit_sel)
                                          : (st.last_levels & ~bit_sel);
          if (old_lvl != item.level) begin
            fired = armed & st.unmask & bit_sel;
          end
        end
      end
      KIND_READ: begin
        res.bad_access = sel_bad;
        unique case (item.reg_sel)
          SEL_RISE:   res.read_data = st.rise_enable;
          SEL_FALL:   res.read_data = st.fall_enable;
          SEL_SWTRIG: res.read_data = st.soft_trigger;
          SEL_UNMASK: res.read_data = st.unmask;
          SEL_PEND:   res.read_data = st.pending;
          default:    res.read_data = '0;
        endcase
      end
      KIND_WRITE: begin
        res.bad_access = sel_bad;
        unique case (item.reg_sel)
          SEL_RISE:   st_nxt.rise_enable = item.write_data;
          SEL_FALL:   st_nxt.fall_enable = item.write_data;
          SEL_SWTRIG: begin
            st_nxt.soft_trigger = item.write_data;
            fired = item.write_data & (st.rise_enable | st.fall_enable)
                  & st.unmask & LINE_MASK;
          end
          SEL_UNMASK: st_nxt.unmask  = item.write_data;
          SEL_PEND:   st_nxt.pending = st.pending & ~item.write_data;
          default:    ;
        endcase
      end
      default: ;
    endcase

    // edge and software trigger both land here; write-one-clear never fires
    st_nxt.pending = st_nxt.pending | fired;
    res.irq_pulse  = pulses_for(fired);
  end

endmodule

// File: rtl/core/edge_interrupt_line_controller_core.sv
// ---------------------------------------------------------------------------
// edge_interrupt_line_controller_core
// External interrupt line controller with edge detect and register access
// ---------------------------------------------------------------------------
// in_bus carries one beat per line level change, register read or register
// write. out_bus returns exactly one result beat per input beat, in order:
// read data for reads, the interrupt outputs pulsed by that beat, and the
// bad access flag for selects outside the five registers.
// Results are registered. Throughput is one beat per cycle while out_bus
// keeps up, set by the single decode stage between the state registers
// and the result register.
// A two-entry result buffer (output register plus skid register) sits on
// the output side: while out_bus stalls, one more input beat is taken and
// held in the skid entry, then in_bus.ready drops until the skid drains.
// Synchronous reset (rst_n low) clears all registers and line levels to
// zero and empties the result buffer.
// ---------------------------------------------------------------------------
`include "edge_interrupt_line_controller_core_macros.svh"

module edge_interrupt_line_controller_core
  import eilc_pkg::*;
#(
  parameter int unsigned NUM_LINES = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  eilc_in_if.sink          in_bus,
  eilc_out_if.source       out_bus
);

  state_t  st_r, st_nxt;
  item_t   item;
  result_t res;
  result_t out_r, skid_r;
  logic    out_valid_r, skid_valid_r;
  logic    in_fire, out_fire;

  assign item = '{kind: in_bus.kind, line: in_bus.line, level: in_bus.level,
                  reg_sel: in_bus.reg_sel, write_data: in_bus.write_data};

  eilc_decode #(
    .NUM_LINES (NUM_LINES)
  ) u_decode (
    .item   (item),
    .st     (st_r),
    .st_nxt (st_nxt),
    .res    (res)
  );

  assign in_bus.ready = !skid_valid_r;
  assign in_fire      = in_bus.valid && in_bus.ready;
  assign out_fire     = out_valid_r && out_bus.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (in_fire) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_fire) begin
        out_r        <= skid_r;
        skid_valid_r <= 1'b0;
      end
    end else if (in_fire) begin
      if (!out_valid_r || out_fire) begin
        out_r       <= res;
        out_valid_r <= 1'b1;
      end else begin
        // output stalled: park the beat
        skid_r       <= res;
        skid_valid_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_bus.valid      = out_valid_r;
  assign out_bus.read_data  = out_r.read_data;
  assign out_bus.irq_pulse  = out_r.irq_pulse;
  assign out_bus.bad_access = out_r.bad_access;

  `EILC_ASSERT(a_skid_needs_out, skid_valid_r |-> out_valid_r, "skid full with output empty")
  `EILC_ASSERT(a_state_hold, $past(rst_n) && !$past(in_fire) |-> st_r == $past(st_r), "state moved without a beat")
  `EILC_ASSERT(a_bad_clean, out_valid_r && out_r.bad_access |-> out_r.irq_pulse == '0 && out_r.read_data == '0, "bad access result not clean")
  `EILC_ASSERT_ALWAYS(a_rst_clear, !rst_n |=> !out_valid_r && !skid_valid_r && st_r == '0, "reset did not clear")

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the edge interrupt line controller core. A short
// table walks reset values, bad selects, edge firing on all three interrupt
// groups and the software trigger; random line events and register traffic
// follow. Every result beat is checked against the row's result or a line model.
// ---------------------------------------------------------------------------
module tb;
  import eilc_pkg::*;

  localparam int unsigned NUM_LINES    = 32;
  localparam int unsigned RANDOM_BEATS = 880;
  localparam int unsigned CALM_BEATS   = 120;
  localparam int unsigned STALL_LIMIT  = 2000;

  localparam logic [1:0]       KIND_NOP    = 2'd3;
  localparam logic [2:0]       SEL_RSVD_LO = 3'd5;
  localparam logic [2:0]       SEL_RSVD_HI = 3'd7;
  localparam logic [REG_W-1:0] ALL_ONES    = {REG_W{1'b1}};
  localparam logic [REG_W-1:0] LINE_MASK   = ALL_ONES >> (REG_W - NUM_LINES);

  typedef struct {
    item_t   beat;
    bit      typed;
    result_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic calm;

  eilc_in_if  in_bus ();
  eilc_out_if out_bus ();

  edge_interrupt_line_controller_core #(
    .NUM_LINES(NUM_LINES)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .out_bus(out_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // line controller state as the bench sees it
  logic [REG_W-1:0] rise_en  = '0;
  logic [REG_W-1:0] fall_en  = '0;
  logic [REG_W-1:0] swtrig   = '0;
  logic [REG_W-1:0] unmask_r = '0;
  logic [REG_W-1:0] pend     = '0;
  logic [REG_W-1:0] levels   = '0;

  stim_row_t stim_rows[$];
  result_t   irq_results_due[$];
  bit        cur_typed;
  result_t   cur_want;

  int errors       = 0;
  int idle_cycles  = 0;
  int n_beats      = 0;
  int n_line_evts  = 0;
  int n_writes     = 0;
  int n_reads      = 0;
  int n_pulse_hits = 0;
  int n_bad_hits   = 0;

  function automatic logic [IRQ_W-1:0] outputs_for_lines(input logic [REG_W-1:0] lines);
    logic [IRQ_W-1:0] outs;
    outs = '0;
    for (int k = 0; k < 16; k++) begin
      if (lines[k]) begin
        if (k < 5) outs[k] = 1'b1;
        else if (k < 10) outs[5] = 1'b1;
        else outs[6] = 1'b1;
      end
    end
    return outs;
  endfunction

  // advances the line state by one beat and returns the result it causes
  function automatic result_t apply_line_beat(input item_t b);
    result_t          r;
    logic [REG_W-1:0] line_bit;
    logic [REG_W-1:0] armed;
    logic [REG_W-1:0] fired;
    r = '0;
    case (b.kind)
      KIND_LINE: begin
        if (b.line < NUM_LINES) begin
          line_bit = '0;
          line_bit[b.line] = 1'b1;
          if (levels[b.line] != b.level) begin
            armed = b.level ? rise_en : fall_en;
            if ((armed & unmask_r & line_bit) != '0) begin
              pend |= line_bit;
              r.irq_pulse = outputs_for_lines(line_bit);
            end
          end
          levels[b.line] = b.level;
        end
      end
      KIND_READ: begin
        case (b.reg_sel)
          SEL_RISE:   r.read_data = rise_en;
          SEL_FALL:   r.read_data = fall_en;
          SEL_SWTRIG: r.read_data = swtrig;
          SEL_UNMASK: r.read_data = unmask_r;
          SEL_PEND:   r.read_data = pend;
          default:    r.bad_access = 1'b1;
        endcase
      end
      KIND_WRITE: begin
        case (b.reg_sel)
          SEL_RISE:   rise_en = b.write_data;
          SEL_FALL:   fall_en = b.write_data;
          SEL_SWTRIG: begin
            swtrig = b.write_data;
            fired = b.write_data & (rise_en | fall_en) & unmask_r & LINE_MASK;
            pend |= fired;
            r.irq_pulse = outputs_for_lines(fired);
          end
          SEL_UNMASK: unmask_r = b.write_data;
          SEL_PEND:   pend &= ~b.write_data;
          default:    r.bad_access = 1'b1;
        endcase
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void add_row(input logic [1:0] kind, input logic [4:0] line,
                                  input logic level, input logic [2:0] sel,
                                  input logic [REG_W-1:0] data, input bit typed,
                                  input logic [REG_W-1:0] rd, input logic [IRQ_W-1:0] irq,
                                  input logic bad);
    stim_row_t row;
    row.beat.kind       = kind;
    row.beat.line       = line;
    row.beat.level      = level;
    row.beat.reg_sel    = sel;
    row.beat.write_data = data;
    row.typed           = typed;
    row.want.read_data  = rd;
    row.want.irq_pulse  = irq;
    row.want.bad_access = bad;
    stim_rows.push_back(row);
  endfunction

  function automatic item_t random_line_beat();
    item_t b;
    int    pick;
    b.kind       = KIND_LINE;
    b.reg_sel    = 3'($urandom_range(0, 7));
    b.write_data = $urandom;
    b.line       = ($urandom_range(0, 3) != 0) ? 5'($urandom_range(0, 15))
                                               : 5'($urandom_range(0, 31));
    b.level      = ($urandom_range(0, 9) < 7) ? ~levels[b.line] : 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 99);
    if (pick < 22) begin
      b.kind = KIND_WRITE;
      pick = $urandom_range(0, 19);
      if (pick < 4) b.reg_sel = SEL_RISE;
      else if (pick < 8) b.reg_sel = SEL_FALL;
      else if (pick < 12) b.reg_sel = SEL_UNMASK;
      else if (pick < 15) b.reg_sel = SEL_SWTRIG;
      else if (pick < 19) b.reg_sel = SEL_PEND;
      else b.reg_sel = 3'($urandom_range(SEL_RSVD_LO, SEL_RSVD_HI));
      pick = $urandom_range(0, 9);
      if (pick == 0) b.write_data = '0;
      else if (pick == 1) b.write_data = ALL_ONES;
      else if (pick < 6) b.write_data = $urandom | $urandom;
    end else if (pick < 44) begin
      b.kind = KIND_READ;
      b.reg_sel = ($urandom_range(0, 9) != 0) ? 3'($urandom_range(0, 4))
                                              : 3'($urandom_range(SEL_RSVD_LO, SEL_RSVD_HI));
    end else if (pick < 48) begin
      b.kind = KIND_NOP;
    end
    return b;
  endfunction

  // drives one beat from a falling edge and returns at the falling edge after it is taken
  task automatic send_beat(input item_t b, input bit typed, input result_t want);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_bus.valid      <= 1'b1;
    in_bus.kind       <= b.kind;
    in_bus.line       <= b.line;
    in_bus.level      <= b.level;
    in_bus.reg_sel    <= b.reg_sel;
    in_bus.write_data <= b.write_data;
    cur_typed         <= typed;
    cur_want          <= want;
    @(posedge clk);
    while (!(in_bus.valid && in_bus.ready)) @(posedge clk);
    @(negedge clk);
  endtask

  // both channels seen at the rising edge: predict on input, check on output
  always @(posedge clk) begin : monitor
    item_t   seen;
    result_t want;
    result_t got;
    if (!rst_n) begin
      idle_cycles <= 0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        seen.kind       = in_bus.kind;
        seen.line       = in_bus.line;
        seen.level      = in_bus.level;
        seen.reg_sel    = in_bus.reg_sel;
        seen.write_data = in_bus.write_data;
        want = apply_line_beat(seen);
        if (cur_typed) want = cur_want;
        irq_results_due.push_back(want);
        n_beats++;
        if (seen.kind == KIND_LINE) n_line_evts++;
        if (seen.kind == KIND_WRITE) n_writes++;
        if (seen.kind == KIND_READ) n_reads++;
      end
      if (out_bus.valid && out_bus.ready) begin
        got.read_data  = out_bus.read_data;
        got.irq_pulse  = out_bus.irq_pulse;
        got.bad_access = out_bus.bad_access;
        if (got.irq_pulse != '0) n_pulse_hits++;
        if (got.bad_access) n_bad_hits++;
        if (irq_results_due.size() == 0) begin
          $error("result beat with nothing expected");
          errors++;
        end else begin
          want = irq_results_due.pop_front();
          if (got.read_data !== want.read_data) begin
            $error("read_data: expected %h, got %h", want.read_data, got.read_data);
            errors++;
          end
          if (got.irq_pulse !== want.irq_pulse) begin
            $error("irq_pulse: expected %h, got %h", want.irq_pulse, got.irq_pulse);
            errors++;
          end
          if (got.bad_access !== want.bad_access) begin
            $error("bad_access: expected %b, got %b", want.bad_access, got.bad_access);
            errors++;
          end
        end
      end
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // result side: stall bursts between go stretches, always ready once calm
  initial begin : sink
    int left;
    left = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (calm) begin
        out_bus.ready <= 1'b1;
      end else if (left == 0) begin
        if ($urandom_range(0, 1) == 0) begin
          out_bus.ready <= 1'b0;
          left = $urandom_range(1, 14);
        end else begin
          out_bus.ready <= 1'b1;
          left = $urandom_range(1, 40);
        end
      end else begin
        left--;
      end
    end
  end

  initial begin : watchdog
    wait (rst_n === 1'b1);
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    item_t   b;
    result_t none;
    none = '0;
    rst_n             <= 1'b0;
    calm              <= 1'b0;
    in_bus.valid      <= 1'b0;
    in_bus.kind       <= KIND_LINE;
    in_bus.line       <= '0;
    in_bus.level      <= 1'b0;
    in_bus.reg_sel    <= SEL_RISE;
    in_bus.write_data <= '0;
    cur_typed         <= 1'b0;
    cur_want          <= '0;

    // reset values, bad selects, unknown kind
    add_row(KIND_READ,  5'd0,  1'b0, SEL_PEND,    '0,       1, '0,       '0, 1'b0);
    add_row(KIND_READ,  5'd0,  1'b0, SEL_RISE,    '0,       1, '0,       '0, 1'b0);
    add_row(KIND_READ,  5'd0,  1'b0, SEL_RSVD_LO, '0,       1, '0,       '0, 1'b1);
    add_row(KIND_WRITE, 5'd0,  1'b0, SEL_RSVD_HI, ALL_ONES, 1, '0,       '0, 1'b1);
    add_row(KIND_NOP,   5'd31, 1'b1, SEL_RSVD_HI, ALL_ONES, 1, '0,       '0, 1'b0);
    // line change with a bad select and nothing armed, then arm every edge and unmask
    add_row(KIND_LINE,  5'd3,  1'b1, SEL_RSVD_HI, '0,       1, '0,       '0, 1'b0);
    add_row(KIND_WRITE, 5'd0,  1'b0, SEL_RISE,    ALL_ONES, 1, '0,       '0, 1'b0);
    add_row(KIND_WRITE, 5'd0,  1'b0, SEL_FALL,    ALL_ONES, 1, '0,       '0, 1'b0);
    add_row(KIND_WRITE, 5'd0,  1'b0, SEL_UNMASK,  ALL_ONES, 1, '0,       '0, 1'b0);
    // edges: same level again, refire while pending, line with no output
    add_row(KIND_LINE,  5'd0,  1'b1, SEL_RISE,    '0,       0, '0,       '0, 1'b0);
    add_row(KIND_LINE,  5'd0,  1'b1, SEL_RISE,    '0,       0, '0,       '0, 1'b0);
    add_row(KIND_LINE,  5'd0,  1'b0, SEL_RISE,    '0,       0, '0,       '0, 1'b0);
    add_row(KIND_LINE,  5'd31, 1'b1, SEL_RISE,    '0,       0, '0,       '0, 1'b0);
    add_row(KIND_LINE,  5'd7,  1'b1, SEL_RISE,    '0,       0, '0,       '0, 1'b0);
    add_row(KIND_LINE,  5'd15, 1'b1, SEL_RISE,    '0,       0, '0,       '0, 1'b0);
    add_row(KIND_LINE,  5'd3,  1'b0, SEL_RISE,    '0,       0, '0,       '0, 1'b0);
    // software trigger on every line, shared outputs collapse to one bit
    add_row(KIND_WRITE, 5'd0,  1'b0, SEL_SWTRIG,  ALL_ONES, 0, '0,       '0, 1'b0);
    add_row(KIND_READ,  5'd0,  1'b0, SEL_SWTRIG,  '0,       1, ALL_ONES, '0, 1'b0);
    add_row(KIND_READ,  5'd0,  1'b0, SEL_PEND,    '0,       1, ALL_ONES, '0, 1'b0);
    add_row(KIND_WRITE, 5'd0,  1'b0, SEL_PEND,    ALL_ONES, 1, '0,       '0, 1'b0);
    add_row(KIND_READ,  5'd0,  1'b0, SEL_PEND,    '0,       1, '0,       '0, 1'b0);
    add_row(KIND_WRITE, 5'd0,  1'b0, SEL_UNMASK,  '0,       1, '0,       '0, 1'b0);
    add_row(KIND_LINE,  5'd9,  1'b1, SEL_RISE,    '0,       0, '0,       '0, 1'b0);
    add_row(KIND_READ,  5'd0,  1'b0, SEL_FALL,    '0,       1, ALL_ONES, '0, 1'b0);
    add_row(KIND_READ,  5'd0,  1'b0, SEL_UNMASK,  '0,       1, '0,       '0, 1'b0);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (stim_rows[i]) send_beat(stim_rows[i].beat, stim_rows[i].typed, stim_rows[i].want);

    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n == RANDOM_BEATS - CALM_BEATS) calm <= 1'b1;
      b = random_line_beat();
      send_beat(b, 1'b0, none);
    end
    in_bus.valid <= 1'b0;

    while (irq_results_due.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);

    $display("%0d beats: %0d line events, %0d register writes, %0d reads",
             n_beats, n_line_evts, n_writes, n_reads);
    $display("%0d results carried interrupt pulses, %0d flagged a bad select",
             n_pulse_hits, n_bad_hits);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/eilc_pkg.sv
rtl/core/eilc_if.sv
rtl/core/eilc_decode.sv
rtl/core/edge_interrupt_line_controller_core.sv
tb/sv/tb.sv
